>>> rtl/asx_pkg.sv
package asx_pkg;

  localparam int KEY_WORDS_DEF      = 4;
  localparam int EXPANDED_WORDS_DEF = 16;

  localparam logic [31:0] RK_A = 32'h1763af12;
  localparam logic [31:0] RK_B = 32'hd1bb5770;
  localparam logic [31:0] RK_C = 32'h2b3a55bb;

  localparam int RND_W = 7;
  localparam logic [RND_W-1:0] ROUNDS_ABSORB  = 7'd12;
  localparam logic [RND_W-1:0] ROUNDS_MIX     = 7'd72;
  localparam logic [RND_W-1:0] ROUNDS_SQUEEZE = 7'd36;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } sponge_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // absorb the incoming key word into a
    logic clear;    // start of a new key: zero the sponge while loading
    logic rnd;      // run one round
    logic capture;  // copy a into the output register
  } asx_cmd_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    rotr32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic sponge_t sponge_round(input sponge_t s);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    sponge_t     r;
    x = s.a ^ RK_A;
    y = s.b ^ RK_B;
    z = s.c ^ RK_C;
    z = z + x;
    x = rotr32(x, 9);
    y = y ^ z;
    z = rotr32(z, 16);
    x = x + y;
    z = z ^ x;
    x = rotr32(x, 17);
    y = y + z;
    z = rotr32(z, 8);
    r.a = y;
    r.b = z;
    r.c = x;
    sponge_round = r;
  endfunction

endpackage

>>> rtl/asx_datapath.sv
module asx_datapath (
  input  logic             clk,
  input  asx_pkg::asx_cmd_t cmd,
  input  logic [31:0]      key_word,
  output logic [31:0]      expanded_word
);

  asx_pkg::sponge_t st;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st.a <= (cmd.clear ? 32'd0 : st.a) ^ key_word;
      st.b <= cmd.clear ? 32'd0 : st.b;
      st.c <= cmd.clear ? 32'd0 : st.c;
    end else if (cmd.rnd) begin
      st <= asx_pkg::sponge_round(st);
    end
    if (cmd.capture) begin
      expanded_word <= st.a;
    end
  end

endmodule

>>> rtl/asx_controller.sv
module asx_controller #(
  parameter int KEY_WORDS      = asx_pkg::KEY_WORDS_DEF,
  parameter int EXPANDED_WORDS = asx_pkg::EXPANDED_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output asx_pkg::asx_cmd_t cmd
);

  localparam int KW_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int EW_W = (EXPANDED_WORDS > 1) ? $clog2(EXPANDED_WORDS) : 1;

  typedef enum logic [2:0] {IDLE, ABSORB, MIX, SQUEEZE, EMIT} state_t;

  state_t                     state;
  logic [asx_pkg::RND_W-1:0]  rnd_cnt;
  logic [KW_W-1:0]            words;
  logic [EW_W-1:0]            out_cnt;
  logic                       out_free;

  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == IDLE);
  assign cmd.load    = (state == IDLE) && in_valid;
  assign cmd.clear   = (words == '0);
  assign cmd.rnd     = (state == ABSORB) || (state == MIX) || (state == SQUEEZE);
  assign cmd.capture = (state == EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rnd_cnt   <= '0;
      words     <= '0;
      out_cnt   <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state   <= ABSORB;
            rnd_cnt <= asx_pkg::ROUNDS_ABSORB - 1'b1;
          end
        end
        ABSORB: begin
          if (rnd_cnt == '0) begin
            if (words == KW_W'(KEY_WORDS - 1)) begin
              words   <= '0;
              state   <= MIX;
              rnd_cnt <= asx_pkg::ROUNDS_MIX - 1'b1;
            end else begin
              words <= words + 1'b1;
              state <= IDLE;
            end
          end else begin
            rnd_cnt <= rnd_cnt - 1'b1;
          end
        end
        MIX: begin
          if (rnd_cnt == '0) begin
            state   <= SQUEEZE;
            rnd_cnt <= asx_pkg::ROUNDS_SQUEEZE - 1'b1;
            out_cnt <= '0;
          end else begin
            rnd_cnt <= rnd_cnt - 1'b1;
          end
        end
        SQUEEZE: begin
          if (rnd_cnt == '0) begin
            state <= EMIT;
          end else begin
            rnd_cnt <= rnd_cnt - 1'b1;
          end
        end
        EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_last <= (out_cnt == EW_W'(EXPANDED_WORDS - 1));
            if (out_cnt == EW_W'(EXPANDED_WORDS - 1)) begin
              state <= IDLE;
            end else begin
              out_cnt <= out_cnt + 1'b1;
              state   <= SQUEEZE;
              rnd_cnt <= asx_pkg::ROUNDS_SQUEEZE - 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/arx_sponge_key_expander.sv
// Each key word takes one transfer plus 12 rounds, one round per cycle in the shared
// round unit. The last word of a key adds 72 mixing rounds, then each expanded word
// takes 36 rounds plus a capture; the capture waits while the output side stalls.
// The first result follows the absorb rounds of the last key word, the mixing and a squeeze.
// Synchronous reset clears the controller and the output valid; the sponge holds no reset.
module arx_sponge_key_expander #(
  parameter int KEY_WORDS      = asx_pkg::KEY_WORDS_DEF,
  parameter int EXPANDED_WORDS = asx_pkg::EXPANDED_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] expanded_word
  output logic        m_tlast
);

  asx_pkg::asx_cmd_t cmd;

  asx_controller #(
    .KEY_WORDS      (KEY_WORDS),
    .EXPANDED_WORDS (EXPANDED_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .cmd       (cmd)
  );

  asx_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .key_word      (s_tdata),
    .expanded_word (m_tdata)
  );

  // busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted during absorb rounds");

  // input still blocked in the last absorb round
  a_absorb_len: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##12 !s_tready)
    else $error("absorb phase ended early");

  // only the final expanded word of a key may still wait while input is ready
  a_pending_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("input ready while squeeze unfinished");

  // no capture while a result is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !cmd.capture)
    else $error("output register overwritten");

endmodule

>>> bench/tb_arx_sponge_key_expander.sv
`timescale 1ns / 1ps

module tb_arx_sponge_key_expander;

  localparam int KEY_WORDS      = asx_pkg::KEY_WORDS_DEF;
  localparam int EXPANDED_WORDS = asx_pkg::EXPANDED_WORDS_DEF;
  localparam int DIRECTED_KEYS  = 6;
  localparam int RANDOM_KEYS    = 84;
  localparam int CALM_KEYS      = 10;   // tail of the run without idling
  localparam int HOLD_KEY       = 20;   // random key at which the long output stall starts
  localparam int HOLD_CYCLES    = 3000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } expanded_t;

  // Software sponge that predicts every expanded word of each key.
  class expansion_scoreboard;
    logic [31:0] st_a;
    logic [31:0] st_b;
    logic [31:0] st_c;
    int          words_taken;
    expanded_t   expected_words[$];
    int          errors;

    function new();
      st_a = '0;
      st_b = '0;
      st_c = '0;
      words_taken = 0;
      errors = 0;
    endfunction

    function void mix_round();
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      x = st_a ^ asx_pkg::RK_A;
      y = st_b ^ asx_pkg::RK_B;
      z = st_c ^ asx_pkg::RK_C;
      z = z + x;
      x = {x[8:0], x[31:9]};
      y = y ^ z;
      z = {z[15:0], z[31:16]};
      x = x + y;
      z = z ^ x;
      x = {x[16:0], x[31:17]};
      y = y + z;
      z = {z[7:0], z[31:8]};
      st_a = y;
      st_b = z;
      st_c = x;
    endfunction

    function void run_mix(int n);
      for (int i = 0; i < n; i++) mix_round();
    endfunction

    function void note_key_word(logic [31:0] w);
      expanded_t e;
      if (words_taken == 0) begin
        st_a = '0;
        st_b = '0;
        st_c = '0;
      end
      st_a = st_a ^ w;
      run_mix(int'(asx_pkg::ROUNDS_ABSORB));
      words_taken++;
      if (words_taken < KEY_WORDS) return;
      words_taken = 0;
      run_mix(int'(asx_pkg::ROUNDS_MIX));
      for (int k = 0; k < EXPANDED_WORDS; k++) begin
        run_mix(int'(asx_pkg::ROUNDS_SQUEEZE));
        e.word = st_a;
        e.last = (k == EXPANDED_WORDS - 1);
        expected_words.push_back(e);
      end
    endfunction

    function void check_result(logic [31:0] word, logic last);
      expanded_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected result: expanded_word %h, last_word %b", word, last);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word) begin
        $error("expanded_word: expected %h, actual %h", e.word, word);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_word: expected %b, actual %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] expanded_word
  logic        m_tlast;

  expansion_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  arx_sponge_key_expander dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one key word, at times after a random idle gap, and hold it until the transfer.
  task automatic send_key_word(input logic [31:0] w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_key_word(w);
  endtask

  function automatic logic [31:0] pick_key_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Output side: sample transfers, then choose tready for the next cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] directed_keys [DIRECTED_KEYS][KEY_WORDS];
    directed_keys[0] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    directed_keys[1] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    directed_keys[2] = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
    directed_keys[3] = '{32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_fffe};
    directed_keys[4] = '{asx_pkg::RK_A, asx_pkg::RK_B, asx_pkg::RK_C, 32'h0000_0000};
    directed_keys[5] = '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_KEYS; k++)
      for (int i = 0; i < KEY_WORDS; i++) send_key_word(directed_keys[k][i]);

    for (int k = 0; k < RANDOM_KEYS; k++) begin
      if (k == HOLD_KEY) hold_req = 1'b1;
      if (k == RANDOM_KEYS - CALM_KEYS) idle_on = 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) send_key_word(pick_key_word());
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
